>>> design/kfq_pkg.sv
// Shared types and constants for the keyed-remove FIFO queue.
// This package depends on nothing. The top level and its sequencer logic use it.
`default_nettype none

package kfq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 32;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int VALUE_W           = 32;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_APPEND = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_LIST   = 2'd2;

    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_FULL     = 2'd1;
    localparam status_t STAT_NOTFOUND = 2'd2;
    localparam status_t STAT_EMPTY    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_LIST  = 4'b1000
    } state_t;

endpackage : kfq_pkg

`default_nettype wire

>>> design/kfq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// This module depends on nothing.
`default_nettype none

module kfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : kfq_ram

`default_nettype wire

>>> design/keyed_remove_fifo_queue.sv
// Keyed-remove FIFO queue: ordered (value, priority) store held in one RAM.
// Depends on kfq_pkg and kfq_ram.
// Append: result in the cycle after acceptance and busy stays low, so one append a cycle.
// Remove searches one entry a cycle; its result follows the search cycle that decides it,
// and compaction then moves one entry a cycle. Remove and list hold busy until they have
// walked the queue, so the next item waits for them; results are never held off.
// Reset clears occupancy and the sequencer; RAM contents stay undefined, no clearing pass.
`default_nettype none

module keyed_remove_fifo_queue #(
    parameter int QUEUE_DEPTH   = kfq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = kfq_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire kfq_pkg::cmd_t                       command,
    input  wire logic signed [kfq_pkg::VALUE_W-1:0]  value,
    input  wire logic [PRIORITY_BITS-1:0]            priority_req,
    output logic                                     strobe,
    output kfq_pkg::status_t                         status,
    output logic signed [kfq_pkg::VALUE_W-1:0]       entry_value,
    output logic [PRIORITY_BITS-1:0]                 entry_priority,
    output logic                                     last
);

    import kfq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_W = PRIORITY_BITS + VALUE_W;

    state_t                   state_reg, state_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [PRIORITY_BITS-1:0] key_reg, key_next;

    logic                     strobe_reg, strobe_next;
    status_t                  status_reg, status_next;
    logic [VALUE_W-1:0]       val_reg, val_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     last_reg, last_next;

    logic                     accept;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [MEM_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [MEM_W-1:0]         ram_rdata;
    logic [VALUE_W-1:0]       rd_val;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [OCC_W-1:0]         idx_ext;
    logic                     idx_is_last;
    logic                     is_full;

    kfq_ram #(
        .WIDTH (MEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign rd_val      = ram_rdata[VALUE_W-1:0];
    assign rd_prio     = ram_rdata[MEM_W-1:VALUE_W];
    assign idx_ext     = OCC_W'(idx_reg);
    assign idx_is_last = (idx_ext == occ_reg - OCC_W'(1));
    assign is_full     = (occ_reg == OCC_W'(QUEUE_DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        val_next    = val_reg;
        prio_next   = prio_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg + IDX_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                idx_next  = '0;
                if (accept)
                begin
                    key_next = priority_req;
                    unique case (command) inside
                        CMD_APPEND:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            val_next    = value;
                            prio_next   = priority_req;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                ram_we      = 1'b1;
                                ram_waddr   = occ_reg[IDX_W-1:0];
                                ram_wdata   = {priority_req, value};
                                occ_next    = occ_reg + OCC_W'(1);
                            end
                        end
                        CMD_REMOVE, CMD_LIST:
                        begin
                            if (occ_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                status_next = STAT_EMPTY;
                                val_next    = '0;
                                prio_next   = '0;
                            end
                            else if (command == CMD_REMOVE)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // An undefined command is taken and dropped.
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // The read for the next slot is issued while this one is checked.
                idx_next = idx_reg + IDX_W'(1);
                if (rd_prio == key_reg)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = STAT_OK;
                    val_next    = rd_val;
                    prio_next   = rd_prio;
                    occ_next    = occ_reg - OCC_W'(1);
                    idx_next    = idx_reg;
                    state_next  = idx_is_last ? S_IDLE : S_SHIFT;
                end
                else if (idx_is_last)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = STAT_NOTFOUND;
                    val_next    = '0;
                    prio_next   = '0;
                    state_next  = S_IDLE;
                end
            end

            S_SHIFT:
            begin
                // Read data holds the entry behind the slot being filled.
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                ram_raddr = idx_reg + IDX_W'(2);
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_ext + OCC_W'(1) == occ_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_LIST:
            begin
                strobe_next = 1'b1;
                status_next = STAT_OK;
                val_next    = rd_val;
                prio_next   = rd_prio;
                last_next   = idx_is_last;
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_is_last)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        prio_reg   <= prio_next;
        last_reg   <= last_next;
    end

    assign strobe         = strobe_reg;
    assign status         = status_reg;
    assign entry_value    = signed'(val_reg);
    assign entry_priority = prio_reg;
    assign last           = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_LIST) |-> occ_reg != '0)
        else $error("search or listing on an empty queue");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_ext < occ_reg && ram_raddr != ram_waddr))
        else $error("compaction write outside the queue or colliding with its read");

    a_shift_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |=> !strobe_reg)
        else $error("result issued during compaction");

endmodule : keyed_remove_fifo_queue

`default_nettype wire

>>> sim/kfq_scoreboard_pkg.sv
// Scoreboard for the keyed-remove FIFO queue testbench: a predictor of the queue
// contents and a store of the results still to arrive from the block.
// Depends on kfq_pkg for the command and status codes and the default sizes.
package kfq_scoreboard_pkg;

    import kfq_pkg::*;

    localparam int   QUEUE_SLOTS = QUEUE_DEPTH_DEF;
    localparam int   PRIO_W      = PRIORITY_BITS_DEF;
    // The block accepts this code and does nothing with it.
    localparam cmd_t CMD_UNUSED  = 2'd3;

    typedef struct {
        status_t                     status;
        logic signed [VALUE_W-1:0]   entry_value;
        logic [PRIO_W-1:0]           entry_priority;
        logic                        last;
    } queue_result_t;

    class queue_scoreboard;

        logic signed [VALUE_W-1:0] stored_value [QUEUE_SLOTS];
        logic [PRIO_W-1:0]         stored_prio [QUEUE_SLOTS];
        int                        occupancy = 0;
        queue_result_t             awaited [$];

        int errors        = 0;
        int results_seen  = 0;
        int appends       = 0;
        int appends_full  = 0;
        int removes       = 0;
        int removes_miss  = 0;
        int removes_empty = 0;
        int lists         = 0;
        int ignored       = 0;

        function void await_result(status_t s, logic signed [VALUE_W-1:0] v,
                                   logic [PRIO_W-1:0] p, logic l);
            queue_result_t r;
            r.status         = s;
            r.entry_value    = v;
            r.entry_priority = p;
            r.last           = l;
            awaited.push_back(r);
        endfunction

        // Called for every item the block accepts; updates the predicted queue
        // and queues the results that the item must produce.
        function void note_command(cmd_t c, logic signed [VALUE_W-1:0] v,
                                   logic [PRIO_W-1:0] p);
            int hit;
            hit = -1;
            case (c)
                CMD_APPEND:
                begin
                    appends++;
                    if (occupancy >= QUEUE_SLOTS)
                    begin
                        appends_full++;
                        await_result(STAT_FULL, v, p, 1'b1);
                    end
                    else
                    begin
                        stored_value[occupancy] = v;
                        stored_prio[occupancy]  = p;
                        occupancy++;
                        await_result(STAT_OK, v, p, 1'b1);
                    end
                end
                CMD_REMOVE:
                begin
                    removes++;
                    if (occupancy == 0)
                    begin
                        removes_empty++;
                        await_result(STAT_EMPTY, '0, '0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < occupancy; i++)
                            if (hit < 0 && stored_prio[i] == p)
                                hit = i;
                        if (hit < 0)
                        begin
                            removes_miss++;
                            await_result(STAT_NOTFOUND, '0, '0, 1'b1);
                        end
                        else
                        begin
                            await_result(STAT_OK, stored_value[hit], stored_prio[hit], 1'b1);
                            for (int j = hit; j + 1 < occupancy; j++)
                            begin
                                stored_value[j] = stored_value[j + 1];
                                stored_prio[j]  = stored_prio[j + 1];
                            end
                            occupancy--;
                        end
                    end
                end
                CMD_LIST:
                begin
                    lists++;
                    if (occupancy == 0)
                        await_result(STAT_EMPTY, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < occupancy; i++)
                            await_result(STAT_OK, stored_value[i], stored_prio[i],
                                         i == occupancy - 1);
                end
                default:
                    ignored++;
            endcase
        endfunction

        function void check_result(status_t s, logic signed [VALUE_W-1:0] v,
                                    logic [PRIO_W-1:0] p, logic l);
            queue_result_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got status %0d value %0d",
                         $time, s, v, " priority %0d last %0b", p, l);
                return;
            end
            want = awaited.pop_front();
            if (s !== want.status)
            begin
                errors++;
                $display("%0t: status: expected %0d, got %0d", $time, want.status, s);
            end
            if (v !== want.entry_value)
            begin
                errors++;
                $display("%0t: entry_value: expected %0d, got %0d",
                         $time, want.entry_value, v);
            end
            if (p !== want.entry_priority)
            begin
                errors++;
                $display("%0t: entry_priority: expected %0d, got %0d",
                         $time, want.entry_priority, p);
            end
            if (l !== want.last)
            begin
                errors++;
                $display("%0t: last: expected %0b, got %0b", $time, want.last, l);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

    endclass

endpackage : kfq_scoreboard_pkg

>>> sim/keyed_remove_fifo_queue_tb.sv
// Testbench for keyed_remove_fifo_queue: directed and random append, remove and
// list commands, with every result checked against a predicted queue.
// Depends on kfq_pkg, kfq_scoreboard_pkg and the block's RTL.
module keyed_remove_fifo_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kfq_pkg::*;
    import kfq_scoreboard_pkg::*;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    cmd_t                      command      = CMD_APPEND;
    logic signed [VALUE_W-1:0] value        = '0;
    logic [PRIO_W-1:0]         priority_req = '0;
    logic                      busy;
    logic                      strobe;
    status_t                   status;
    logic signed [VALUE_W-1:0] entry_value;
    logic [PRIO_W-1:0]         entry_priority;
    logic                      last;

    queue_scoreboard sb = new();
    int              idle_pct = 0;
    bit              filling  = 1'b1;

    keyed_remove_fifo_queue u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .value          (value),
        .priority_req   (priority_req),
        .strobe         (strobe),
        .status         (status),
        .entry_value    (entry_value),
        .entry_priority (entry_priority),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Everything seen here was settled before the edge, so the order of
    // processes within the step does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                sb.check_result(status, entry_value, entry_priority, last);
            if (start && !busy)
                sb.note_command(command, value, priority_req);
        end
    end

    // Presents one item, possibly after a random gap, and returns on the edge
    // that accepts it. start stays high when the next item follows at once.
    task automatic issue_command(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                                 input logic [PRIO_W-1:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= c;
        value        <= v;
        priority_req <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(9) == 0)
            case ($urandom_range(3))
                0: v = VALUE_MIN;
                1: v = VALUE_MAX;
                2: v = '0;
                default: v = -1;
            endcase
        return v;
    endfunction

    // A narrow set of priorities most of the time, so that removals find
    // matches and duplicate keys are common.
    function automatic logic [PRIO_W-1:0] pick_priority();
        if ($urandom_range(3) == 0)
            return PRIO_W'($urandom_range(255));
        return PRIO_W'($urandom_range(7));
    endfunction

    // The mix leans towards appends until the queue fills, then towards
    // removals until it drains, so both the full and the empty queue are met.
    task automatic issue_random();
        int                roll;
        int                occ;
        logic [PRIO_W-1:0] key;
        occ = sb.occupancy;
        if (occ >= QUEUE_SLOTS && $urandom_range(1) == 0)
            filling = 1'b0;
        else if (occ == 0 && $urandom_range(1) == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (roll < 3)
            issue_command(CMD_UNUSED, pick_value(), pick_priority());
        else if (roll < 10)
            issue_command(CMD_LIST, pick_value(), pick_priority());
        else if (roll < (filling ? 75 : 35))
            issue_command(CMD_APPEND, pick_value(), pick_priority());
        else
        begin
            key = pick_priority();
            if (occ > 0 && $urandom_range(9) < 7)
                key = sb.stored_prio[$urandom_range(occ - 1)];
            issue_command(CMD_REMOVE, pick_value(), key);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 17;
        issue_command(CMD_LIST,   '0,        8'h00);
        issue_command(CMD_REMOVE, '0,        8'h00);
        issue_command(CMD_APPEND, VALUE_MIN, 8'h00);
        issue_command(CMD_APPEND, VALUE_MAX, 8'hFF);
        issue_command(CMD_APPEND, -1,        8'h55);
        issue_command(CMD_APPEND, '0,        8'hAA);
        issue_command(CMD_APPEND, 123,       8'hFF);
        issue_command(CMD_LIST,   VALUE_MAX, 8'hFF);
        issue_command(CMD_REMOVE, '0,        8'h01);
        // The older of the two entries with the same key goes first.
        issue_command(CMD_REMOVE, '0,        8'hFF);
        issue_command(CMD_REMOVE, '0,        8'h00);
        issue_command(CMD_UNUSED, VALUE_MIN, 8'hFF);
        // Removing the newest entry must leave the tail in the right place.
        issue_command(CMD_REMOVE, '0,        8'hFF);
        issue_command(CMD_APPEND, 7,         8'h03);
        issue_command(CMD_LIST,   '0,        8'h00);
        issue_command(CMD_REMOVE, -1,        8'h03);
        issue_command(CMD_REMOVE, '0,        8'h55);
        issue_command(CMD_REMOVE, '0,        8'hAA);
        issue_command(CMD_REMOVE, '0,        8'hAA);
        issue_command(CMD_LIST,   '0,        8'h00);
        issue_command(CMD_UNUSED, VALUE_MAX, 8'h00);
        issue_command(CMD_APPEND, 32'h5A5A_A5A5, 8'h80);
        issue_command(CMD_LIST,   '0,        8'h00);

        repeat (100) issue_random();
        idle_pct = 87;
        repeat (100) issue_random();
        idle_pct = 0;
        repeat (100) issue_random();
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (2 * QUEUE_SLOTS + 8) @(posedge clk);

        $display("Sent %0d appends (%0d refused as full), %0d removals (%0d unmatched,",
                 sb.appends, sb.appends_full, sb.removes, sb.removes_miss,
                 " %0d on an empty queue), %0d lists and %0d undefined commands.",
                 sb.removes_empty, sb.lists, sb.ignored);
        $display("Checked %0d results against the predicted queue contents.",
                 sb.results_seen);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule : keyed_remove_fifo_queue_tb
